// ----- hw/rtl/sti_pkg.sv -----
package sti_pkg;

	// Default table depth
	localparam int DEPTH_DEFAULT = 16;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_BEYOND    = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         found_index;
		logic signed [31:0] read_value;
		logic [4:0]         entry_count;
	} rsp_t;

endpackage

// ----- hw/rtl/sorted_table_insert_search.sv -----
// Sorted table of signed 32-bit values held in one single-port-read,
// single-port-write memory with registered read data. One item is worked
// at a time; req_stall is high while an item is in progress. An insert
// shifts larger entries up one place, with one memory read and one write
// per cycle while shifting; an insert into a full or empty table needs no
// shifting. A search is a binary search with one memory read per probe.
// The registered read data paces both the shift loop and the search
// probes. A result waits in an output register until taken; the next item
// is accepted once the result has moved there.
module sorted_table_insert_search #(
	parameter int DEPTH = sti_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sti_pkg::req_t req_item,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sti_pkg::rsp_t rsp_item
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_PUT,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_RD_WAIT,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        j_q;
	logic signed [31:0]   val_q;
	logic signed [CW:0]   lo_q;
	logic signed [CW:0]   hi_q;
	logic [CW:0]          mid_q;
	sti_pkg::rsp_t        res_q;
	logic                 rsp_valid_q;
	sti_pkg::rsp_t        rsp_q;

	logic signed [31:0]   mem [DEPTH];
	logic signed [31:0]   rd_data_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic signed [31:0]   mem_wd;
	logic                 mem_re;
	logic [AW-1:0]        mem_ra;

	logic                 accept;
	logic                 out_free;
	logic                 is_full;
	logic [CW-1:0]        cnt_m1;
	logic [CW-1:0]        j_m1;
	logic [CW-1:0]        j_m2;
	logic [CW+1:0]        lohi_sum;
	logic [CW:0]          mid;
	logic [31:0]          pos_ext;
	logic                 pos_ok;

	// Resize an index or count to the fixed output field widths
	function automatic logic [3:0] idx4(input logic [CW:0] x);
		logic [31:0] w;
		w = 32'(x);
		return w[3:0];
	endfunction

	function automatic logic [4:0] cnt5(input logic [CW-1:0] x);
		logic [31:0] w;
		w = 32'(x);
		return w[4:0];
	endfunction

	// Assemble a whole result item
	function automatic sti_pkg::rsp_t mk_res(input logic [1:0] st, input logic [3:0] idx,
			input logic signed [31:0] rv, input logic [4:0] cnt);
		sti_pkg::rsp_t r;
		r.status      = st;
		r.found_index = idx;
		r.read_value  = rv;
		r.entry_count = cnt;
		return r;
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	assign is_full  = (cnt_q == CW'(DEPTH));
	assign cnt_m1   = cnt_q - CW'(1);
	assign j_m1     = j_q - CW'(1);
	assign j_m2     = j_q - CW'(2);
	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = lohi_sum[CW+1:1];
	assign pos_ext  = 32'(req_item.position);
	assign pos_ok   = pos_ext < 32'(cnt_q);

	// Memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = j_q[AW-1:0];
		mem_wd = val_q;
		mem_re = 1'b0;
		mem_ra = cnt_m1[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_item.operation)
						sti_pkg::OP_INSERT: begin
							if (!is_full && cnt_q == '0) begin
								mem_we = 1'b1;
								mem_wa = '0;
								mem_wd = req_item.value;
							end else if (!is_full) begin
								mem_re = 1'b1;
								mem_ra = cnt_m1[AW-1:0];
							end
						end
						sti_pkg::OP_READ: begin
							mem_re = pos_ok;
							mem_ra = pos_ext[AW-1:0];
						end
						default: ;
					endcase
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				mem_wa = j_q[AW-1:0];
				if (val_q < rd_data_q) begin
					mem_wd = rd_data_q;
					mem_re = (j_q != CW'(1));
					mem_ra = j_m2[AW-1:0];
				end else begin
					mem_wd = val_q;
				end
			end
			S_INS_PUT: begin
				mem_we = 1'b1;
				mem_wa = j_q[AW-1:0];
				mem_wd = val_q;
			end
			S_SRCH_RD: begin
				mem_re = (lo_q <= hi_q);
				mem_ra = mid[AW-1:0];
			end
			default: ;
		endcase
	end

	// Table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// Sequencer, result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			j_q         <= '0;
			val_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
		end else begin
			// output valid: set on hand-over, cleared once taken
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q <= req_item.value;
						case (req_item.operation)
							sti_pkg::OP_INSERT: begin
								if (is_full) begin
									res_q   <= mk_res(sti_pkg::ST_FULL, '0, 32'sd0,
										cnt5(cnt_q));
									state_q <= S_DONE;
								end else if (cnt_q == '0) begin
									cnt_q   <= CW'(1);
									res_q   <= mk_res(sti_pkg::ST_OK, '0, 32'sd0,
										cnt5(CW'(1)));
									state_q <= S_DONE;
								end else begin
									j_q     <= cnt_q;
									state_q <= S_INS_CMP;
								end
							end
							sti_pkg::OP_SEARCH: begin
								lo_q    <= '0;
								hi_q    <= $signed({1'b0, cnt_q}) - (CW+1)'(1);
								state_q <= S_SRCH_RD;
							end
							sti_pkg::OP_READ: begin
								if (pos_ok) begin
									state_q <= S_RD_WAIT;
								end else begin
									res_q   <= mk_res(sti_pkg::ST_BEYOND, '0, 32'sd0,
										cnt5(cnt_q));
									state_q <= S_DONE;
								end
							end
							default: begin
								cnt_q   <= '0;
								res_q   <= mk_res(sti_pkg::ST_OK, '0, 32'sd0, cnt5('0));
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS_CMP: begin
					if (val_q < rd_data_q) begin
						j_q <= j_m1;
						if (j_q == CW'(1)) begin
							state_q <= S_INS_PUT;
						end
					end else begin
						res_q   <= mk_res(sti_pkg::ST_OK, idx4({1'b0, j_q}), 32'sd0,
							cnt5(cnt_q + CW'(1)));
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_INS_PUT: begin
					res_q   <= mk_res(sti_pkg::ST_OK, idx4({1'b0, j_q}), 32'sd0,
						cnt5(cnt_q + CW'(1)));
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_DONE;
				end
				S_SRCH_RD: begin
					if (lo_q <= hi_q) begin
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else begin
						res_q   <= mk_res(sti_pkg::ST_NOT_FOUND, '0, 32'sd0,
							cnt5(cnt_q));
						state_q <= S_DONE;
					end
				end
				S_SRCH_CMP: begin
					if (rd_data_q == val_q) begin
						res_q   <= mk_res(sti_pkg::ST_OK, idx4(mid_q), 32'sd0,
							cnt5(cnt_q));
						state_q <= S_DONE;
					end else if (val_q < rd_data_q) begin
						hi_q    <= $signed(mid_q) - (CW+1)'(1);
						state_q <= S_SRCH_RD;
					end else begin
						lo_q    <= $signed(mid_q) + (CW+1)'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_RD_WAIT: begin
					res_q   <= mk_res(sti_pkg::ST_OK, '0, rd_data_q, cnt5(cnt_q));
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> (j_q != '0) && (j_q <= cnt_q))
		else $error("shift index out of range");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH_CMP |-> mid_q < {1'b0, cnt_q})
		else $error("search probe beyond entries in use");

	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !req_valid) |-> !mem_we)
		else $error("table write while idle");

	a_rsp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> rsp_item.entry_count == cnt5(cnt_q))
		else $error("result entry count differs from table count");

endmodule

// ----- test/tb_sorted_table_insert_search.sv -----
module tb_sorted_table_insert_search;

	localparam int TABLE_DEPTH  = sti_pkg::DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 1850;
	localparam int QUIET_ITEMS  = 200;
	localparam int HOLD_AT      = 500;
	localparam int PAUSE_AT     = 1100;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 600000;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		sti_pkg::req_t req;
		bit            typed;
		sti_pkg::rsp_t rsp;
	} stim_row_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	sti_pkg::req_t req_item  = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	sti_pkg::rsp_t rsp_item;

	// mirror of the table contents
	logic signed [31:0] table_entries [TABLE_DEPTH];
	int unsigned        table_count = 0;

	sti_pkg::rsp_t pending_rsps [$];
	sti_pkg::rsp_t expected_rsp;
	stim_row_t     directed_rows [$];
	int            error_count = 0;
	int            cycle_count = 0;
	int            total_items = 0;
	bit            quiet       = 1'b0;
	bit            hold_req    = 1'b0;

	sorted_table_insert_search #(
		.DEPTH(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

	always #10 clk = ~clk;

	// Apply one item to the mirrored table and return the result it gives
	function automatic sti_pkg::rsp_t table_apply(sti_pkg::req_t it);
		sti_pkg::rsp_t r;
		int            j;
		int            lo;
		int            hi;
		int            mid;
		bit            hit;
		r = '0;
		r.status = sti_pkg::ST_OK;
		case (it.operation)
			sti_pkg::OP_INSERT: begin
				if (table_count >= TABLE_DEPTH) begin
					r.status = sti_pkg::ST_FULL;
				end else begin
					// shift larger entries up; equal ones stay ahead
					j = table_count;
					while (j > 0 && it.value < table_entries[j-1]) begin
						table_entries[j] = table_entries[j-1];
						j--;
					end
					table_entries[j] = it.value;
					table_count++;
					r.found_index = j[3:0];
				end
			end
			sti_pkg::OP_SEARCH: begin
				lo  = 0;
				hi  = int'(table_count) - 1;
				hit = 1'b0;
				while (lo <= hi && !hit) begin
					mid = (lo + hi) / 2;
					if (table_entries[mid] == it.value) begin
						hit = 1'b1;
						r.found_index = mid[3:0];
					end else if (it.value < table_entries[mid]) begin
						hi = mid - 1;
					end else begin
						lo = mid + 1;
					end
				end
				if (!hit)
					r.status = sti_pkg::ST_NOT_FOUND;
			end
			sti_pkg::OP_READ: begin
				if (it.position < table_count)
					r.read_value = table_entries[it.position];
				else
					r.status = sti_pkg::ST_BEYOND;
			end
			default: begin
				table_count = 0;
			end
		endcase
		r.entry_count = table_count[4:0];
		return r;
	endfunction

	function automatic sti_pkg::req_t mk_req(logic [1:0] op, logic signed [31:0] v,
			logic [3:0] p);
		sti_pkg::req_t it;
		it.operation = op;
		it.value     = v;
		it.position  = p;
		return it;
	endfunction

	function automatic sti_pkg::rsp_t mk_rsp(logic [1:0] st, logic [3:0] idx,
			logic signed [31:0] rv, logic [4:0] cnt);
		sti_pkg::rsp_t r;
		r.status      = st;
		r.found_index = idx;
		r.read_value  = rv;
		r.entry_count = cnt;
		return r;
	endfunction

	function automatic void add_row(sti_pkg::req_t it, bit typed, sti_pkg::rsp_t r);
		stim_row_t row;
		row.req   = it;
		row.typed = typed;
		row.rsp   = r;
		directed_rows.push_back(row);
	endfunction

	// Random item, weighted toward inserts and lookups of stored values
	function automatic sti_pkg::req_t random_request();
		sti_pkg::req_t it;
		int            pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			it.operation = sti_pkg::OP_INSERT;
		else if (pick < 75)
			it.operation = sti_pkg::OP_SEARCH;
		else if (pick < 97)
			it.operation = sti_pkg::OP_READ;
		else
			it.operation = sti_pkg::OP_CLEAR;
		it.position = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0: it.value = $urandom;
			1: it.value = int'($urandom_range(0, 8)) - 4;
			2: begin
				case ($urandom_range(0, 3))
					0: it.value = VAL_MIN;
					1: it.value = VAL_MAX;
					2: it.value = 32'sd0;
					default: it.value = -32'sd1;
				endcase
			end
			default: begin
				if (table_count > 0)
					it.value = table_entries[$urandom_range(0, table_count - 1)];
				else
					it.value = $urandom;
			end
		endcase
		// searches mostly look for something that is stored
		if (it.operation == sti_pkg::OP_SEARCH && table_count > 0
				&& $urandom_range(0, 1) == 1)
			it.value = table_entries[$urandom_range(0, table_count - 1)];
		return it;
	endfunction

	// Offer one item, wait for acceptance, then record its expected result
	task automatic offer_item(input stim_row_t row, input int item_no);
		sti_pkg::rsp_t predicted;
		quiet = (item_no >= total_items - QUIET_ITEMS);
		if (item_no == PAUSE_AT) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while (pending_rsps.size() != 0)
				@(posedge clk);
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		if (item_no == HOLD_AT)
			hold_req = 1'b1;
		req_valid <= 1'b1;
		req_item  <= row.req;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = table_apply(row.req);
		pending_rsps.push_back(row.typed ? row.rsp : predicted);
	endtask

	// Result side stall pattern
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t: result with none expected: expected none, actual %p",
					$time, rsp_item);
				error_count++;
			end else begin
				expected_rsp = pending_rsps.pop_front();
				if (rsp_item.status !== expected_rsp.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, expected_rsp.status, rsp_item.status);
					error_count++;
				end
				if (rsp_item.found_index !== expected_rsp.found_index) begin
					$display("%0t: found_index expected %0d actual %0d",
						$time, expected_rsp.found_index, rsp_item.found_index);
					error_count++;
				end
				if (rsp_item.read_value !== expected_rsp.read_value) begin
					$display("%0t: read_value expected %0d actual %0d",
						$time, expected_rsp.read_value, rsp_item.read_value);
					error_count++;
				end
				if (rsp_item.entry_count !== expected_rsp.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d",
						$time, expected_rsp.entry_count, rsp_item.entry_count);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        item_no;

		// empty table after reset
		add_row(mk_req(sti_pkg::OP_SEARCH, VAL_MAX, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_NOT_FOUND, 4'd0, 32'sd0, 5'd0));
		add_row(mk_req(sti_pkg::OP_READ, 32'sd0, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_BEYOND, 4'd0, 32'sd0, 5'd0));
		// extremes and a duplicate that must land after its twin
		add_row(mk_req(sti_pkg::OP_INSERT, VAL_MAX, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_OK, 4'd0, 32'sd0, 5'd1));
		add_row(mk_req(sti_pkg::OP_INSERT, 32'sd0, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_OK, 4'd0, 32'sd0, 5'd2));
		add_row(mk_req(sti_pkg::OP_INSERT, 32'sd0, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_OK, 4'd1, 32'sd0, 5'd3));
		add_row(mk_req(sti_pkg::OP_INSERT, VAL_MIN, 4'd15), 1'b1,
			mk_rsp(sti_pkg::ST_OK, 4'd0, 32'sd0, 5'd4));
		// fill the rest of the table
		for (int i = 0; i < TABLE_DEPTH - 4; i++)
			add_row(mk_req(sti_pkg::OP_INSERT, $urandom, 4'($urandom_range(0, 15))),
				1'b0, '0);
		// insert into a full table
		add_row(mk_req(sti_pkg::OP_INSERT, 32'sd5, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_FULL, 4'd0, 32'sd0, 5'd16));
		add_row(mk_req(sti_pkg::OP_READ, 32'sd0, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_OK, 4'd0, VAL_MIN, 5'd16));
		add_row(mk_req(sti_pkg::OP_READ, 32'sd0, 4'd15), 1'b1,
			mk_rsp(sti_pkg::ST_OK, 4'd0, VAL_MAX, 5'd16));
		add_row(mk_req(sti_pkg::OP_SEARCH, VAL_MIN, 4'd0), 1'b0, '0);
		add_row(mk_req(sti_pkg::OP_SEARCH, 32'sd0, 4'd0), 1'b0, '0);
		add_row(mk_req(sti_pkg::OP_SEARCH, 32'sd1, 4'd0), 1'b0, '0);
		// clear, then the empty cases again
		add_row(mk_req(sti_pkg::OP_CLEAR, -32'sd1, 4'd15), 1'b1,
			mk_rsp(sti_pkg::ST_OK, 4'd0, 32'sd0, 5'd0));
		add_row(mk_req(sti_pkg::OP_SEARCH, 32'sd0, 4'd0), 1'b1,
			mk_rsp(sti_pkg::ST_NOT_FOUND, 4'd0, 32'sd0, 5'd0));
		add_row(mk_req(sti_pkg::OP_READ, 32'sd0, 4'd15), 1'b1,
			mk_rsp(sti_pkg::ST_BEYOND, 4'd0, 32'sd0, 5'd0));

		total_items = directed_rows.size() + RANDOM_ITEMS;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		item_no = 0;
		foreach (directed_rows[i]) begin
			offer_item(directed_rows[i], item_no);
			item_no++;
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			row.req   = random_request();
			row.typed = 1'b0;
			row.rsp   = '0;
			offer_item(row, item_no);
			item_no++;
		end
		req_valid <= 1'b0;

		// drain outstanding results
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_rsps.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
